FILE: rtl/kinematic_arrive_steering_core_defines.svh
// assertion macros used by the port-level checker of the steering core
`ifndef KINEMATIC_ARRIVE_STEERING_CORE_DEFINES_SVH
`define KINEMATIC_ARRIVE_STEERING_CORE_DEFINES_SVH

// same-cycle implication, sampled on the core clock outside reset
`define KAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define KAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/kas_pkg.sv
// shared widths, register codes and pipeline sideband types of the steering core
`default_nettype none
package kas_pkg;

   localparam int XY_W      = 32;
   localparam int CFG_W     = 31;
   localparam int REQ_W     = 6 * XY_W;
   localparam int RSP_W     = 2 * XY_W;
   localparam int CSR_IDX_W = 3;
   localparam int ROOT_W    = 32;
   localparam int RAD_W     = 63;
   localparam int PROD_W    = 2 * CFG_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE           = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_TO_TARGET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_RADIUS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_RADIUS    = 3'd4;

   // mode codes, the upper code also selects arrive
   localparam logic [1:0] MODE_SEEK   = 2'd0;
   localparam logic [1:0] MODE_FLEE   = 2'd1;
   localparam logic [1:0] MODE_ARRIVE = 2'd2;

   // sideband through the first square root
   typedef struct packed {
      logic              arrive;
      logic              flip;
      logic              sgn_x;
      logic              sgn_y;
      logic              in_tgt;
      logic              slow;
      logic              nz;
      logic [XY_W-1:0]   vel_x;
      logic [XY_W-1:0]   vel_y;
      logic [PROD_W-1:0] num_x;
      logic [PROD_W-1:0] num_y;
   } sq1_side_type;

   // sideband through the first divider, x lane
   typedef struct packed {
      logic            arrive;
      logic            flip;
      logic            sgn_x;
      logic            in_tgt;
      logic            nz;
      logic [XY_W-1:0] vel_x;
   } d1x_side_type;

   // sideband through the first divider, y lane
   typedef struct packed {
      logic            sgn_y;
      logic [XY_W-1:0] vel_y;
   } d1y_side_type;

   // sideband for an item whose answer is already settled
   typedef struct packed {
      logic            done;
      logic            in_tgt;
      logic            esx;
      logic [XY_W-1:0] res_x;
      logic [XY_W-1:0] res_y;
   } fin_side_type;

   // sideband through the second square root
   typedef struct packed {
      fin_side_type      fin;
      logic              esy;
      logic              clip;
      logic [CFG_W-1:0]  bx;
      logic [CFG_W-1:0]  by;
      logic [PROD_W-1:0] num_x;
      logic [PROD_W-1:0] num_y;
   } sq2_side_type;

   // sideband through the last divider, x lane
   typedef struct packed {
      fin_side_type     fin;
      logic             clip;
      logic             lnz;
      logic [CFG_W-1:0] bx;
   } d3x_side_type;

   // sideband through the last divider, y lane
   typedef struct packed {
      logic             esy;
      logic [CFG_W-1:0] by;
   } d3y_side_type;

endpackage
`default_nettype wire

FILE: rtl/kas_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module kas_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       ce,
   input  logic                       in_valid,
   input  logic [kas_pkg::RAD_W-1:0]  in_rad,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                       out_valid,
   output logic [kas_pkg::ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0]          out_side
);
   import kas_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int SR_W  = 2 * ROOT_W;

   logic              valid_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff   [ROOT_W];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   logic [SR_W-1:0]   rad_ff   [ROOT_W];
   logic [SIDE_W-1:0] side_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic              valid_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SR_W-1:0]   rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  subtr;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = SR_W'(in_rad);
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign rad_prev   = rad_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      // bring down two radicand bits and try the next root bit
      always_comb begin
         trial = {rem_prev[REM_W-3:0], rad_prev[SR_W-1 -: 2]};
         subtr = {1'b0, root_prev, 2'b01};
         if (trial >= subtr) begin
            rem_in  = trial - subtr;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ce) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= {rad_prev[SR_W-3:0], 2'b00};
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/kas_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module kas_div #(
   parameter int NUM_W  = 62,
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 31,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ce,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);
   import kas_pkg::*;

   // numerator bits above QUO_W must already be below the divisor
   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  quo_ff   [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic              valid_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = DEN_W'(in_num >> QUO_W);
         assign quo_prev   = in_num[QUO_W-1:0];
         assign den_prev   = in_den;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign quo_prev   = quo_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      // shift in the next numerator bit and subtract when it fits
      always_comb begin
         trial  = {rem_prev, quo_prev[QUO_W-1]};
         ge     = trial >= {1'b0, den_prev};
         rem_in = ge ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ce) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[i]  <= rem_in;
            quo_ff[i]  <= {quo_prev[QUO_W-2:0], ge};
            den_ff[i]  <= den_prev;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
`default_nettype wire

FILE: rtl/kinematic_arrive_steering_core.sv
// top level of the seek, flee and arrive steering pipeline
//
//  channel | direction | contents
//  req     | in        | tdata: target_x, target_y, pos_x, pos_y, vel_x, vel_y
//  rsp     | out       | tdata: steer_x, steer_y; tuser: inside_target
//  csr     | in        | csr_index register number, csr_data value
//
// one request enters per clock while no result is held on rsp; the path runs through
// two 32-stage square roots, two 31-stage dividers and one (33 + FRAC_BITS)-stage divider
// synchronous active-high reset clears all valid bits and loads register defaults
// a held result on rsp freezes the whole pipeline; req_tready follows that freeze
// csr writes are taken every cycle and should only happen while the pipeline is empty
`default_nettype none
module kinematic_arrive_steering_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // target_x, target_y, pos_x, pos_y, vel_x, vel_y (32 bits each)
   input  logic [kas_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // steer_x, steer_y (32 bits each)
   output logic [kas_pkg::RSP_W-1:0]     rsp_tdata,
   // inside_target
   output logic [0:0]                    rsp_tuser,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [kas_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [kas_pkg::CFG_W-1:0]     csr_data
);
   import kas_pkg::*;

   localparam int D3_W = XY_W + 1 + FRAC_BITS;
   localparam int HI_W = D3_W - CFG_W;
   localparam int S2_W = $clog2(HI_W + 1);

   // length of the part of a word above bit 30
   function automatic logic [S2_W-1:0] hi_len(logic [HI_W-1:0] v);
      logic [S2_W-1:0] n;
      n = '0;
      for (int i = 0; i < HI_W; i++) begin
         if (v[i]) begin
            n = S2_W'(i + 1);
         end
      end
      return n;
   endfunction

   // apply a sign to a 31-bit magnitude
   function automatic logic [XY_W-1:0] put(logic neg, logic [CFG_W-1:0] m);
      return neg ? XY_W'(-{1'b0, m}) : {1'b0, m};
   endfunction

   // configuration registers
   logic [1:0]       mode_ff;
   logic [CFG_W-1:0] max_speed_ff, time_to_target_ff, target_radius_ff, slow_radius_ff;
   logic [PROD_W-1:0] ms_sq_ff, tr_sq_ff, sr_sq_ff;
   logic [CFG_W-1:0] ttt_eff;
   logic             arrive, flip;

   assign csr_ready = 1'b1;
   assign arrive    = mode_ff[1];
   assign flip      = mode_ff == MODE_FLEE;
   assign ttt_eff   = (time_to_target_ff == '0) ? CFG_W'(1) : time_to_target_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_ARRIVE;
         max_speed_ff      <= CFG_W'(65536);
         time_to_target_ff <= CFG_W'(65536);
         target_radius_ff  <= CFG_W'(65536);
         slow_radius_ff    <= CFG_W'(262144);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:           mode_ff           <= csr_data[1:0];
            CSR_MAX_SPEED:      max_speed_ff      <= csr_data;
            CSR_TIME_TO_TARGET: time_to_target_ff <= csr_data;
            CSR_TARGET_RADIUS:  target_radius_ff  <= csr_data;
            CSR_SLOW_RADIUS:    slow_radius_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // squared limits, refreshed every cycle
   always_ff @(posedge clock) begin
      ms_sq_ff <= PROD_W'(max_speed_ff) * PROD_W'(max_speed_ff);
      tr_sq_ff <= PROD_W'(target_radius_ff) * PROD_W'(target_radius_ff);
      sr_sq_ff <= PROD_W'(slow_radius_ff) * PROD_W'(slow_radius_ff);
   end

   // global advance: move unless a result is held
   logic ce;
   logic rsp_valid_ff;
   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = ce;

   // stage 1: position differences
   logic              v1_ff;
   logic [XY_W:0]     dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic [XY_W-1:0]   vx1_ff, vy1_ff;

   always_comb begin
      dx1_in = {req_tdata[31], req_tdata[31:0]} - {req_tdata[95], req_tdata[95:64]};
      dy1_in = {req_tdata[63], req_tdata[63:32]} - {req_tdata[127], req_tdata[127:96]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ce) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         vx1_ff <= req_tdata[159:128];
         vy1_ff <= req_tdata[191:160];
      end
   end

   // stage 2: magnitudes and the common shift into 31 bits
   logic              v2_ff, sx2_ff, sy2_ff, s02_ff;
   logic [CFG_W-1:0]  ex2_ff, ey2_ff, ex2_in, ey2_in;
   logic [XY_W-1:0]   vx2_ff, vy2_ff;
   logic [XY_W:0]     ax, ay, am;

   always_comb begin
      ax = dx1_ff[XY_W] ? -dx1_ff : dx1_ff;
      ay = dy1_ff[XY_W] ? -dy1_ff : dy1_ff;
      am = ax | ay;
      if (am[XY_W]) begin
         ex2_in = ax[XY_W:2];
         ey2_in = ay[XY_W:2];
      end else if (am[XY_W-1]) begin
         ex2_in = ax[XY_W-1:1];
         ey2_in = ay[XY_W-1:1];
      end else begin
         ex2_in = ax[CFG_W-1:0];
         ey2_in = ay[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ce) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ex2_ff <= ex2_in;
         ey2_ff <= ey2_in;
         sx2_ff <= dx1_ff[XY_W];
         sy2_ff <= dy1_ff[XY_W];
         s02_ff <= !am[XY_W] && !am[XY_W-1];
         vx2_ff <= vx1_ff;
         vy2_ff <= vy1_ff;
      end
   end

   // stage 3: squares and speed products
   logic              v3_ff, sx3_ff, sy3_ff, s03_ff;
   logic [PROD_W-1:0] exx3_ff, eyy3_ff, nmx3_ff, nmy3_ff;
   logic [XY_W-1:0]   vx3_ff, vy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ce) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         exx3_ff <= PROD_W'(ex2_ff) * PROD_W'(ex2_ff);
         eyy3_ff <= PROD_W'(ey2_ff) * PROD_W'(ey2_ff);
         nmx3_ff <= PROD_W'(ex2_ff) * PROD_W'(max_speed_ff);
         nmy3_ff <= PROD_W'(ey2_ff) * PROD_W'(max_speed_ff);
         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         s03_ff  <= s02_ff;
         vx3_ff  <= vx2_ff;
         vy3_ff  <= vy2_ff;
      end
   end

   // stage 4: squared length and radius tests
   logic              v4_ff;
   logic [RAD_W-1:0]  sq4_ff, sq4_in;
   sq1_side_type      s4_ff, s4_in;

   always_comb begin
      sq4_in       = {1'b0, exx3_ff} + {1'b0, eyy3_ff};
      s4_in.arrive = arrive;
      s4_in.flip   = flip;
      s4_in.sgn_x  = sx3_ff;
      s4_in.sgn_y  = sy3_ff;
      s4_in.in_tgt = arrive && s03_ff && (sq4_in < {1'b0, tr_sq_ff});
      s4_in.slow   = arrive && s03_ff && (sq4_in < {1'b0, sr_sq_ff});
      s4_in.nz     = sq4_in != '0;
      s4_in.vel_x  = vx3_ff;
      s4_in.vel_y  = vy3_ff;
      s4_in.num_x  = nmx3_ff;
      s4_in.num_y  = nmy3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (ce) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sq4_ff <= sq4_in;
         s4_ff  <= s4_in;
      end
   end

   // first length
   logic              r1_valid;
   logic [ROOT_W-1:0] r1_root;
   logic [$bits(sq1_side_type)-1:0] r1_side_bits;
   sq1_side_type      r1_side;

   kas_isqrt #(.SIDE_W($bits(sq1_side_type))) u_sqrt_len (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (v4_ff),
      .in_rad   (sq4_ff),
      .in_side  (s4_ff),
      .out_valid(r1_valid),
      .out_root (r1_root),
      .out_side (r1_side_bits)
   );

   assign r1_side = r1_side_bits;

   // desired speed: product over length or over slow radius
   logic [ROOT_W-1:0] den1;
   d1x_side_type      d1x_in, d1x_out;
   d1y_side_type      d1y_in, d1y_out;
   logic [$bits(d1x_side_type)-1:0] d1x_bits;
   logic [$bits(d1y_side_type)-1:0] d1y_bits;
   logic              d1_valid, d1y_valid;
   logic [CFG_W-1:0]  q1x, q1y;

   always_comb begin
      den1          = r1_side.slow ? {1'b0, slow_radius_ff} : r1_root;
      d1x_in.arrive = r1_side.arrive;
      d1x_in.flip   = r1_side.flip;
      d1x_in.sgn_x  = r1_side.sgn_x;
      d1x_in.in_tgt = r1_side.in_tgt;
      d1x_in.nz     = r1_side.nz;
      d1x_in.vel_x  = r1_side.vel_x;
      d1y_in.sgn_y  = r1_side.sgn_y;
      d1y_in.vel_y  = r1_side.vel_y;
   end

   kas_div #(.NUM_W(PROD_W), .DEN_W(ROOT_W), .QUO_W(CFG_W),
             .SIDE_W($bits(d1x_side_type))) u_div_want_x (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (r1_valid),
      .in_num   (r1_side.num_x),
      .in_den   (den1),
      .in_side  (d1x_in),
      .out_valid(d1_valid),
      .out_quo  (q1x),
      .out_side (d1x_bits)
   );

   kas_div #(.NUM_W(PROD_W), .DEN_W(ROOT_W), .QUO_W(CFG_W),
             .SIDE_W($bits(d1y_side_type))) u_div_want_y (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (r1_valid),
      .in_num   (r1_side.num_y),
      .in_den   (den1),
      .in_side  (d1y_in),
      .out_valid(d1y_valid),
      .out_quo  (q1y),
      .out_side (d1y_bits)
   );

   assign d1x_out = d1x_bits;
   assign d1y_out = d1y_bits;

   // stage 5: velocity error, or the settled seek, flee or inside answer
   logic              v5_ff, esy5_ff;
   fin_side_type      f5_ff, f5_in;
   logic [XY_W:0]     emx5_ff, emy5_ff, emx5_in, emy5_in;
   logic [CFG_W-1:0]  qx, qy;
   logic [XY_W:0]     wx, wy;
   logic [XY_W+1:0]   errx, erry;

   always_comb begin
      qx   = d1x_out.nz ? q1x : '0;
      qy   = d1x_out.nz ? q1y : '0;
      wx   = d1x_out.sgn_x ? -{2'b00, qx} : {2'b00, qx};
      wy   = d1y_out.sgn_y ? -{2'b00, qy} : {2'b00, qy};
      errx = {wx[XY_W], wx} - {{2{d1x_out.vel_x[XY_W-1]}}, d1x_out.vel_x};
      erry = {wy[XY_W], wy} - {{2{d1y_out.vel_y[XY_W-1]}}, d1y_out.vel_y};
      emx5_in = errx[XY_W+1] ? (XY_W+1)'(-errx) : (XY_W+1)'(errx);
      emy5_in = erry[XY_W+1] ? (XY_W+1)'(-erry) : (XY_W+1)'(erry);
      f5_in.done   = !d1x_out.arrive || d1x_out.in_tgt;
      f5_in.in_tgt = d1x_out.arrive && d1x_out.in_tgt;
      f5_in.esx    = errx[XY_W+1];
      if (!d1x_out.arrive) begin
         f5_in.res_x = put(d1x_out.sgn_x != d1x_out.flip, qx);
         f5_in.res_y = put(d1y_out.sgn_y != d1x_out.flip, qy);
      end else begin
         f5_in.res_x = '0;
         f5_in.res_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (ce) begin
         v5_ff <= d1_valid && d1y_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f5_ff   <= f5_in;
         emx5_ff <= emx5_in;
         emy5_ff <= emy5_in;
         esy5_ff <= erry[XY_W+1];
      end
   end

   // error over time to target
   logic              d2_valid, d2y_valid;
   logic [D3_W-1:0]   cx, cy;
   logic [$bits(fin_side_type)-1:0] d2x_bits;
   fin_side_type      f6_in;
   logic              esy6_in;

   kas_div #(.NUM_W(D3_W), .DEN_W(CFG_W), .QUO_W(D3_W),
             .SIDE_W($bits(fin_side_type))) u_div_accel_x (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (v5_ff),
      .in_num   ({emx5_ff, FRAC_BITS'(0)}),
      .in_den   (ttt_eff),
      .in_side  (f5_ff),
      .out_valid(d2_valid),
      .out_quo  (cx),
      .out_side (d2x_bits)
   );

   kas_div #(.NUM_W(D3_W), .DEN_W(CFG_W), .QUO_W(D3_W), .SIDE_W(1)) u_div_accel_y (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (v5_ff),
      .in_num   ({emy5_ff, FRAC_BITS'(0)}),
      .in_den   (ttt_eff),
      .in_side  (esy5_ff),
      .out_valid(d2y_valid),
      .out_quo  (cy),
      .out_side (esy6_in)
   );

   assign f6_in = d2x_bits;

   // stage 6: shift needed to bring both components below 2^31
   logic              v6_ff, esy6_ff;
   fin_side_type      f6_ff;
   logic [D3_W-1:0]   cx6_ff, cy6_ff, c_or;
   logic [S2_W-1:0]   s26_ff, s26_in;

   always_comb begin
      c_or   = cx | cy;
      s26_in = hi_len(c_or[D3_W-1:CFG_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (ce) begin
         v6_ff <= d2_valid && d2y_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f6_ff   <= f6_in;
         esy6_ff <= esy6_in;
         cx6_ff  <= cx;
         cy6_ff  <= cy;
         s26_ff  <= s26_in;
      end
   end

   // stage 7: apply the shift
   logic              v7_ff, esy7_ff, shf7_ff;
   fin_side_type      f7_ff;
   logic [CFG_W-1:0]  bx7_ff, by7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (ce) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f7_ff   <= f6_ff;
         esy7_ff <= esy6_ff;
         bx7_ff  <= CFG_W'(cx6_ff >> s26_ff);
         by7_ff  <= CFG_W'(cy6_ff >> s26_ff);
         shf7_ff <= s26_ff != '0;
      end
   end

   // stage 8: squares and speed products of the shifted vector
   logic              v8_ff, esy8_ff, shf8_ff;
   fin_side_type      f8_ff;
   logic [CFG_W-1:0]  bx8_ff, by8_ff;
   logic [PROD_W-1:0] bxx8_ff, byy8_ff, nmx8_ff, nmy8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (ce) begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         f8_ff   <= f7_ff;
         esy8_ff <= esy7_ff;
         shf8_ff <= shf7_ff;
         bx8_ff  <= bx7_ff;
         by8_ff  <= by7_ff;
         bxx8_ff <= PROD_W'(bx7_ff) * PROD_W'(bx7_ff);
         byy8_ff <= PROD_W'(by7_ff) * PROD_W'(by7_ff);
         nmx8_ff <= PROD_W'(bx7_ff) * PROD_W'(max_speed_ff);
         nmy8_ff <= PROD_W'(by7_ff) * PROD_W'(max_speed_ff);
      end
   end

   // stage 9: squared length and clip decision
   logic              v9_ff;
   logic [RAD_W-1:0]  sq9_ff, sq9_in;
   sq2_side_type      s9_ff, s9_in;

   always_comb begin
      sq9_in      = {1'b0, bxx8_ff} + {1'b0, byy8_ff};
      s9_in.fin   = f8_ff;
      s9_in.esy   = esy8_ff;
      s9_in.clip  = shf8_ff || (sq9_in > {1'b0, ms_sq_ff});
      s9_in.bx    = bx8_ff;
      s9_in.by    = by8_ff;
      s9_in.num_x = nmx8_ff;
      s9_in.num_y = nmy8_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (ce) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sq9_ff <= sq9_in;
         s9_ff  <= s9_in;
      end
   end

   // second length
   logic              r2_valid;
   logic [ROOT_W-1:0] r2_root;
   logic [$bits(sq2_side_type)-1:0] r2_side_bits;
   sq2_side_type      r2_side;

   kas_isqrt #(.SIDE_W($bits(sq2_side_type))) u_sqrt_clip (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (v9_ff),
      .in_rad   (sq9_ff),
      .in_side  (s9_ff),
      .out_valid(r2_valid),
      .out_root (r2_root),
      .out_side (r2_side_bits)
   );

   assign r2_side = r2_side_bits;

   // clipped components
   d3x_side_type      d3x_in, d3x_out;
   d3y_side_type      d3y_in, d3y_out;
   logic [$bits(d3x_side_type)-1:0] d3x_bits;
   logic [$bits(d3y_side_type)-1:0] d3y_bits;
   logic              d3_valid, d3y_valid;
   logic [CFG_W-1:0]  q3x, q3y;

   always_comb begin
      d3x_in.fin  = r2_side.fin;
      d3x_in.clip = r2_side.clip;
      d3x_in.lnz  = r2_root != '0;
      d3x_in.bx   = r2_side.bx;
      d3y_in.esy  = r2_side.esy;
      d3y_in.by   = r2_side.by;
   end

   kas_div #(.NUM_W(PROD_W), .DEN_W(ROOT_W), .QUO_W(CFG_W),
             .SIDE_W($bits(d3x_side_type))) u_div_clip_x (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (r2_valid),
      .in_num   (r2_side.num_x),
      .in_den   (r2_root),
      .in_side  (d3x_in),
      .out_valid(d3_valid),
      .out_quo  (q3x),
      .out_side (d3x_bits)
   );

   kas_div #(.NUM_W(PROD_W), .DEN_W(ROOT_W), .QUO_W(CFG_W),
             .SIDE_W($bits(d3y_side_type))) u_div_clip_y (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .in_valid (r2_valid),
      .in_num   (r2_side.num_y),
      .in_den   (r2_root),
      .in_side  (d3y_in),
      .out_valid(d3y_valid),
      .out_quo  (q3y),
      .out_side (d3y_bits)
   );

   assign d3x_out = d3x_bits;
   assign d3y_out = d3y_bits;

   // output register
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_ins_ff;
   logic [CFG_W-1:0] mx, my;

   always_comb begin
      if (d3x_out.clip) begin
         mx = d3x_out.lnz ? q3x : '0;
         my = d3x_out.lnz ? q3y : '0;
      end else begin
         mx = d3x_out.bx;
         my = d3y_out.by;
      end
      if (d3x_out.fin.done) begin
         rsp_data_in = {d3x_out.fin.res_y, d3x_out.fin.res_x};
      end else begin
         rsp_data_in = {put(d3y_out.esy, my), put(d3x_out.fin.esx, mx)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= d3_valid && d3y_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ins_ff  <= d3x_out.fin.in_tgt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ins_ff;

endmodule
`default_nettype wire

FILE: rtl/kas_checker.sv
// port-level checks of the steering core and their binding
`default_nettype none
`include "kinematic_arrive_steering_core_defines.svh"
module kas_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [kas_pkg::RSP_W-1:0]     rsp_tdata,
   input logic [0:0]                    rsp_tuser
);
   import kas_pkg::*;

   // a held result keeps its value
   `KAS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")
   // inside the target radius the vector is zero
   `KAS_ASSERT_NOW(a_inside_zero, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "inside result not zero")
   // a blocked output freezes the input side
   `KAS_ASSERT_NOW(a_stall_front, rsp_tvalid && !rsp_tready, !req_tready, "request taken during output stall")
   // the input side only closes behind a held result
   `KAS_ASSERT_NOW(a_ready_cause, !req_tready, rsp_tvalid && !rsp_tready, "request blocked without output stall")

endmodule

bind kinematic_arrive_steering_core kas_checker u_kas_checker (.*);
`default_nettype wire

FILE: tb/kinematic_arrive_steering_core_checker.sv
// response checker for the steering core: watches all channels, predicts and compares
`timescale 1ns / 100ps
`default_nettype none
module kinematic_arrive_steering_core_checker #(
   parameter int FRAC_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   input  wire                          req_tready,
   input  wire [kas_pkg::REQ_W-1:0]     req_tdata,
   input  wire                          rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire [kas_pkg::RSP_W-1:0]     rsp_tdata,
   input  wire [0:0]                    rsp_tuser,
   input  wire                          csr_valid,
   input  wire                          csr_ready,
   input  wire [kas_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [kas_pkg::CFG_W-1:0]     csr_data,
   output int                           fail_count,
   output int                           pending
);
   import kas_pkg::*;

   typedef struct packed {
      logic [31:0] steer_x;
      logic [31:0] steer_y;
      logic        in_tgt;
   } steer_type;

   steer_type steer_q[$];

   // local copy of the registers
   logic [1:0]  mode_r;
   logic [63:0] max_speed_r, ttt_r, tgt_rad_r, slow_rad_r;

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int fit_shift(logic [63:0] a, logic [63:0] b);
      logic [63:0] m;
      int s;
      m = (a > b) ? a : b;
      s = 0;
      while ((m >> s) > 64'h7FFF_FFFF) s++;
      return s;
   endfunction

   function automatic logic [63:0] abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [31:0] signed_out(bit neg, logic [63:0] m);
      logic [63:0] v;
      v = neg ? -m : m;
      return v[31:0];
   endfunction

   // steering vector for one request under the current registers
   function automatic steer_type predict_steer(logic [REQ_W-1:0] d);
      steer_type r;
      longint dx, dy, vx, vy, wx, wy, errx, erry;
      logic [63:0] ax, ay, ex, ey, sq, len, qx, qy, div, cx, cy, bx, by, sq2, len2;
      int s, s2;
      bit flip;
      dx = longint'($signed(d[31:0])) - longint'($signed(d[95:64]));
      dy = longint'($signed(d[63:32])) - longint'($signed(d[127:96]));
      vx = longint'($signed(d[159:128]));
      vy = longint'($signed(d[191:160]));
      ax = abs64(dx);
      ay = abs64(dy);
      s = fit_shift(ax, ay);
      ex = ax >> s;
      ey = ay >> s;
      sq = ex * ex + ey * ey;
      r = '0;
      // seek and flee
      if (mode_r == MODE_SEEK || mode_r == MODE_FLEE) begin
         flip = (mode_r == MODE_FLEE);
         if (sq != 0) begin
            len = root_floor(sq);
            r.steer_x = signed_out((dx < 0) != flip, ex * max_speed_r / len);
            r.steer_y = signed_out((dy < 0) != flip, ey * max_speed_r / len);
         end
         return r;
      end
      // arrive, inside the target radius
      if (s == 0 && sq < tgt_rad_r * tgt_rad_r) begin
         r.in_tgt = 1'b1;
         return r;
      end
      qx = 0;
      qy = 0;
      if (sq != 0) begin
         if (s == 0 && sq < slow_rad_r * slow_rad_r) begin
            qx = ex * max_speed_r / slow_rad_r;
            qy = ey * max_speed_r / slow_rad_r;
         end else begin
            len = root_floor(sq);
            qx = ex * max_speed_r / len;
            qy = ey * max_speed_r / len;
         end
      end
      wx = (dx < 0) ? -longint'(qx) : longint'(qx);
      wy = (dy < 0) ? -longint'(qy) : longint'(qy);
      errx = wx - vx;
      erry = wy - vy;
      div = (ttt_r != 0) ? ttt_r : 64'd1;
      cx = (abs64(errx) << FRAC_BITS) / div;
      cy = (abs64(erry) << FRAC_BITS) / div;
      // clip to max speed
      s2 = fit_shift(cx, cy);
      bx = cx >> s2;
      by = cy >> s2;
      sq2 = bx * bx + by * by;
      if (s2 > 0 || sq2 > max_speed_r * max_speed_r) begin
         len2 = root_floor(sq2);
         if (len2 != 0) begin
            cx = bx * max_speed_r / len2;
            cy = by * max_speed_r / len2;
         end else begin
            cx = 0;
            cy = 0;
         end
      end
      r.steer_x = signed_out(errx < 0, cx);
      r.steer_y = signed_out(erry < 0, cy);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   assign pending = steer_q.size();

   always @(posedge clock) begin
      steer_type want;
      if (reset) begin
         fail_count = 0;
         mode_r      <= MODE_ARRIVE;
         max_speed_r <= 64'd65536;
         ttt_r       <= 64'd65536;
         tgt_rad_r   <= 64'd65536;
         slow_rad_r  <= 64'd262144;
         steer_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODE:           mode_r      <= csr_data[1:0];
               CSR_MAX_SPEED:      max_speed_r <= 64'(csr_data);
               CSR_TIME_TO_TARGET: ttt_r       <= 64'(csr_data);
               CSR_TARGET_RADIUS:  tgt_rad_r   <= 64'(csr_data);
               CSR_SLOW_RADIUS:    slow_rad_r  <= 64'(csr_data);
               default: ;
            endcase
         end
         // accepted request
         if (req_tvalid && req_tready) steer_q.push_back(predict_steer(req_tdata));
         // accepted response
         if (rsp_tvalid && rsp_tready) begin
            if (steer_q.size() == 0) begin
               $display("unexpected response %h at %0t", rsp_tdata, $realtime);
               fail_count++;
            end else begin
               want = steer_q.pop_front();
               if (rsp_tdata[31:0] !== want.steer_x)
                  report_mismatch("steer_x", rsp_tdata[31:0], want.steer_x);
               if (rsp_tdata[63:32] !== want.steer_y)
                  report_mismatch("steer_y", rsp_tdata[63:32], want.steer_y);
               if (rsp_tuser[0] !== want.in_tgt)
                  report_mismatch("inside_target", 32'(rsp_tuser), 32'(want.in_tgt));
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: tb/kinematic_arrive_steering_core_tb.sv
// stimulus and verdict for the steering core, checking is done by the checker module
`timescale 1ns / 100ps
`default_nettype none
module kinematic_arrive_steering_core_tb;
   import kas_pkg::*;

   localparam int FRAC_BITS = 16;
   localparam int LATENCY   = 169 + FRAC_BITS;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   wire                  req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   wire                  rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   wire [RSP_W-1:0]      rsp_tdata;
   wire [0:0]            rsp_tuser;
   logic                 csr_valid = 1'b0;
   wire                  csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;
   int                   fail_count, pending;

   int   snd_idle_pct = 0;
   int   rcv_idle_pct = 0;
   logic hold_go = 1'b0;
   int   hold_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   kinematic_arrive_steering_core #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   kinematic_arrive_steering_core_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending
   );

   // receiver: random stalls plus a long counted hold-off on request
   always @(posedge clock) begin
      if (hold_go && hold_left == 0) begin
         hold_left = 600;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // hard stop
   initial begin
      #3_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for the pipeline to drain before a register write
   task automatic drain;
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic send_request(logic [31:0] tx, logic [31:0] ty, logic [31:0] px,
                               logic [31:0] py, logic [31:0] vx, logic [31:0] vy);
      if ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vy, vx, py, px, ty, tx};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0007_FFFF;
      endcase
   endfunction

   // random request: often near the target so the radii matter
   task automatic random_request;
      logic [31:0] tx, ty, px, py;
      tx = rand_coord();
      ty = rand_coord();
      case ($urandom_range(0, 3))
         0: begin
            px = rand_coord();
            py = rand_coord();
         end
         1: begin
            px = tx;
            py = ty;
         end
         default: begin
            px = tx + 32'($urandom_range(0, 32'h000A_0000)) - 32'h0005_0000;
            py = ty + 32'($urandom_range(0, 32'h000A_0000)) - 32'h0005_0000;
         end
      endcase
      send_request(tx, ty, px, py, rand_coord(), rand_coord());
   endtask

   task automatic random_burst(int count);
      repeat (count) random_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_idling(int done_items);
      if (done_items < 170) begin
         snd_idle_pct = 17;
         rcv_idle_pct = 66;
      end else if (done_items < 340) begin
         snd_idle_pct = 66;
         rcv_idle_pct = 17;
      end else begin
         snd_idle_pct = 0;
         rcv_idle_pct = 0;
      end
   endtask

   initial begin
      int done_items;
      int burst_len;
      done_items = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(0);

      // directed, reset registers (arrive)
      send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000);
      send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h7FFF_FFFF);
      send_request(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_request(32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
      send_request(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0);
      send_request(32'h0010_0000, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      req_tvalid <= 1'b0;
      drain();

      // directed, seek and flee with coinciding and extreme positions
      write_reg(CSR_MODE, CFG_W'(MODE_SEEK));
      send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
      send_request(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      req_tvalid <= 1'b0;
      drain();
      write_reg(CSR_MODE, CFG_W'(MODE_FLEE));
      send_request(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h0, 32'h0);
      req_tvalid <= 1'b0;
      drain();

      // directed, arrive with zero target radius and zero time to target
      write_reg(CSR_MODE, CFG_W'(MODE_ARRIVE));
      write_reg(CSR_TARGET_RADIUS, '0);
      write_reg(CSR_TIME_TO_TARGET, '0);
      send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'hFFFF_8000);
      send_request(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      send_request(32'h0000_1000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      req_tvalid <= 1'b0;
      drain();

      // random phases over several register settings
      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: write_reg(CSR_MODE, CFG_W'(MODE_SEEK));
            1: begin
               write_reg(CSR_MODE, CFG_W'(MODE_FLEE));
               write_reg(CSR_MAX_SPEED, 31'h7FFF_FFFF);
            end
            2: begin
               write_reg(CSR_MODE, CFG_W'(MODE_ARRIVE));
               write_reg(CSR_MAX_SPEED, 31'h0005_0000);
               write_reg(CSR_TIME_TO_TARGET, 31'h0000_8000);
               write_reg(CSR_TARGET_RADIUS, 31'h0001_0000);
               write_reg(CSR_SLOW_RADIUS, 31'h0004_0000);
            end
            3: begin
               write_reg(CSR_MODE, 31'd3);
               write_reg(CSR_SLOW_RADIUS, 31'h7FFF_FFFF);
               write_reg(CSR_TIME_TO_TARGET, 31'h7FFF_FFFF);
            end
            4: begin
               write_reg(CSR_MAX_SPEED, '0);
               write_reg(CSR_SLOW_RADIUS, '0);
               write_reg(CSR_TIME_TO_TARGET, 31'd1);
            end
            5: begin
               write_reg(CSR_MODE, CFG_W'(MODE_SEEK));
               write_reg(CSR_MAX_SPEED, '0);
            end
            6: begin
               write_reg(CSR_MODE, CFG_W'(MODE_ARRIVE));
               write_reg(CSR_MAX_SPEED, 31'h7FFF_FFFF);
               write_reg(CSR_TARGET_RADIUS, 31'h7FFF_FFFF);
               write_reg(CSR_TIME_TO_TARGET, '0);
            end
            7: begin
               write_reg(CSR_TARGET_RADIUS, 31'h0000_4000);
               write_reg(CSR_SLOW_RADIUS, 31'h0010_0000);
               write_reg(CSR_TIME_TO_TARGET, 31'h0002_0000);
               write_reg(CSR_MAX_SPEED, CFG_W'($urandom));
            end
            default: begin
               write_reg(CSR_MODE, CFG_W'($urandom_range(0, 3)));
               write_reg(CSR_MAX_SPEED, CFG_W'($urandom_range(0, 31'h0010_0000)));
            end
         endcase
         set_idling(done_items);
         // long receiver hold-off while more requests than the pipeline holds keep coming
         burst_len = 33;
         if (ph == 2) begin
            burst_len = 220;
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         random_burst(burst_len);
         done_items += burst_len;
         drain();
      end

      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
